### rtl/core/solenoid_kicker_sequencer_unit_defines.svh
`ifndef SOLENOID_KICKER_SEQUENCER_UNIT_DEFINES_SVH
`define SOLENOID_KICKER_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk and muted during rst
`define SKC_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("skc assertion failed");

// next-cycle implication, checked on clk and muted during rst
`define SKC_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("skc assertion failed");

`endif

### rtl/core/skc_pkg.sv
package skc_pkg;

  localparam int unsigned DUR_W   = 20;
  localparam int unsigned SAFE_W  = 16;
  localparam int unsigned MAXC_W  = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_CHARGE_START = 3'd1,
    OP_CHARGE_STOP  = 3'd2,
    OP_KICK_START   = 3'd3,
    OP_KICK_STOP    = 3'd4,
    OP_SAFE_KICK    = 3'd5
  } skc_op_e;

  typedef enum logic [1:0] {
    SPEED_DEFAULT = 2'd0,
    SPEED_GOAL    = 2'd1,
    SPEED_PASS    = 2'd2,
    SPEED_CHIP    = 2'd3
  } skc_speed_e;

  typedef enum logic [1:0] {
    ST_DONE          = 2'd0,
    ST_MAX_CHARGES   = 2'd1,
    ST_ALREADY_CHG   = 2'd2,
    ST_ALREADY_KICK  = 2'd3
  } skc_status_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_CHARGES    = 3'd0,
    REG_SAFE_PULSE     = 3'd1,
    REG_DEFAULT_CHARGE = 3'd2,
    REG_DISCHARGE      = 3'd3,
    REG_GOAL_CHARGE    = 3'd4,
    REG_PASS_CHARGE    = 3'd5,
    REG_CHIP_CHARGE    = 3'd6,
    REG_KICKER_MODE    = 3'd7
  } skc_reg_e;

  localparam logic [MAXC_W-1:0] RST_MAX_CHARGES    = 4'd6;
  localparam logic [SAFE_W-1:0] RST_SAFE_PULSE     = 16'd15;
  localparam logic [DUR_W-1:0]  RST_DEFAULT_CHARGE = 20'd350000;
  localparam logic [DUR_W-1:0]  RST_DISCHARGE      = 20'd300;
  localparam logic [DUR_W-1:0]  RST_GOAL_CHARGE    = 20'd450000;
  localparam logic [DUR_W-1:0]  RST_PASS_CHARGE    = 20'd250000;
  localparam logic [DUR_W-1:0]  RST_CHIP_CHARGE    = 20'd650000;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] speed;
  } skc_in_t;

  typedef struct packed {
    logic               charge_out;
    logic               discharge1_n;
    logic               discharge2_n;
    logic               is_charging;
    logic               is_kicking;
    logic [COUNT_W-1:0] charge_total;
    logic [1:0]         status;
  } skc_out_t;

  typedef struct packed {
    logic [MAXC_W-1:0] max_charges;
    logic [SAFE_W-1:0] safe_pulse_us;
    logic [DUR_W-1:0]  default_charge_us;
    logic [DUR_W-1:0]  discharge_us;
    logic [DUR_W-1:0]  goal_charge_us;
    logic [DUR_W-1:0]  pass_charge_us;
    logic [DUR_W-1:0]  chip_charge_us;
    logic              kicker_mode;
  } skc_cfg_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

### rtl/core/skc_core.sv
`include "solenoid_kicker_sequencer_unit_defines.svh"

module skc_core
  import skc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  skc_in_t  item,
  input  skc_cfg_t cfg,
  output skc_out_t result
);

  logic                 charging, charging_next;
  logic                 kicking, kicking_next;
  logic                 active_dis, active_dis_next;
  logic [TIME_BITS-1:0] charge_timer, charge_timer_next;
  logic [TIME_BITS-1:0] kick_timer, kick_timer_next;
  logic [COUNT_W-1:0]   charge_count, charge_count_next;

  logic [DUR_W-1:0]     ct_sel;
  logic [31:0]          ct_ext, dis_ext, safe_ext;
  logic [COUNT_W-1:0]   count_bumped;
  logic                 charge_last, kick_last;
  skc_status_e          status;

  always_comb begin
    unique case (skc_speed_e'(item.speed))
      SPEED_GOAL:    ct_sel = cfg.goal_charge_us;
      SPEED_PASS:    ct_sel = cfg.pass_charge_us;
      SPEED_CHIP:    ct_sel = cfg.chip_charge_us;
      SPEED_DEFAULT: ct_sel = cfg.default_charge_us;
      default:       ct_sel = cfg.default_charge_us;
    endcase
  end

  // durations wrap to the timer width
  assign ct_ext   = 32'(ct_sel);
  assign dis_ext  = 32'(cfg.discharge_us);
  assign safe_ext = 32'(cfg.safe_pulse_us);

  assign count_bumped = sat_inc(charge_count);
  assign charge_last  = (charge_timer[TIME_BITS-1:1] == '0);
  assign kick_last    = (kick_timer[TIME_BITS-1:1] == '0);

  always_comb begin
    charging_next     = charging;
    kicking_next      = kicking;
    active_dis_next   = active_dis;
    charge_timer_next = charge_timer;
    kick_timer_next   = kick_timer;
    charge_count_next = charge_count;
    status            = ST_DONE;
    unique case (skc_op_e'(item.op))
      OP_TICK: begin
        if (charging) begin
          if (charge_last) begin
            charging_next     = 1'b0;
            charge_timer_next = '0;
            charge_count_next = count_bumped;
          end else begin
            charge_timer_next = charge_timer - TIME_BITS'(1);
          end
        end
        // kick expiry after charge expiry, so the count ends cleared
        if (kicking) begin
          if (kick_last) begin
            kicking_next      = 1'b0;
            kick_timer_next   = '0;
            charge_count_next = '0;
          end else begin
            kick_timer_next = kick_timer - TIME_BITS'(1);
          end
        end
      end
      OP_CHARGE_START: begin
        if (charge_count >= COUNT_W'(cfg.max_charges)) begin
          status = ST_MAX_CHARGES;
        end else if (charging) begin
          status = ST_ALREADY_CHG;
        end else begin
          charging_next     = 1'b1;
          charge_timer_next = ct_ext[TIME_BITS-1:0];
          charge_count_next = count_bumped;
        end
      end
      OP_CHARGE_STOP: begin
        charging_next     = 1'b0;
        charge_timer_next = '0;
        charge_count_next = count_bumped;
      end
      OP_KICK_START: begin
        if (kicking) begin
          status = ST_ALREADY_KICK;
        end else begin
          kicking_next    = 1'b1;
          active_dis_next = cfg.kicker_mode;
          kick_timer_next = dis_ext[TIME_BITS-1:0];
        end
      end
      OP_KICK_STOP: begin
        kicking_next      = 1'b0;
        kick_timer_next   = '0;
        charge_count_next = '0;
      end
      OP_SAFE_KICK: begin
        if (kicking) begin
          status = ST_ALREADY_KICK;
        end else begin
          kicking_next    = 1'b1;
          active_dis_next = 1'b0;
          kick_timer_next = safe_ext[TIME_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charging     <= 1'b0;
      kicking      <= 1'b0;
      active_dis   <= 1'b0;
      charge_timer <= '0;
      kick_timer   <= '0;
      charge_count <= '0;
    end else if (en) begin
      charging     <= charging_next;
      kicking      <= kicking_next;
      active_dis   <= active_dis_next;
      charge_timer <= charge_timer_next;
      kick_timer   <= kick_timer_next;
      charge_count <= charge_count_next;
    end
  end

  assign result.charge_out   = charging_next;
  assign result.discharge1_n = ~(kicking_next & active_dis_next);
  assign result.discharge2_n = ~(kicking_next & ~active_dis_next);
  assign result.is_charging  = charging_next;
  assign result.is_kicking   = kicking_next;
  assign result.charge_total = charge_count_next;
  assign result.status       = status;

  `SKC_ASSERT_NXT(a_kick_stop_clears, en && (item.op == OP_KICK_STOP),
    !kicking && (charge_count == '0))
  `SKC_ASSERT_NXT(a_charge_start_runs,
    en && (item.op == OP_CHARGE_START) && (status == ST_DONE), charging)

endmodule

### rtl/core/solenoid_kicker_sequencer_unit.sv
// two register stages: an accepted item waits in the input register until the result register can take its result
// throughput: one item per cycle, limited only by out_ready backpressure
// a full result register still lets an empty input register take the next item
// reset: synchronous rst clears the valid flags, the charge and kick state and the count
// reset also returns every configuration register to its default value

`include "solenoid_kicker_sequencer_unit_defines.svh"

module solenoid_kicker_sequencer_unit
  import skc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  skc_in_t           in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output skc_out_t          out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  skc_cfg_t cfg;
  logic     in_valid_q;
  skc_in_t  in_q;
  logic     advance;
  skc_out_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_charges       <= RST_MAX_CHARGES;
      cfg.safe_pulse_us     <= RST_SAFE_PULSE;
      cfg.default_charge_us <= RST_DEFAULT_CHARGE;
      cfg.discharge_us      <= RST_DISCHARGE;
      cfg.goal_charge_us    <= RST_GOAL_CHARGE;
      cfg.pass_charge_us    <= RST_PASS_CHARGE;
      cfg.chip_charge_us    <= RST_CHIP_CHARGE;
      cfg.kicker_mode       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (skc_reg_e'(cfg_index))
        REG_MAX_CHARGES:    cfg.max_charges       <= cfg_data[MAXC_W-1:0];
        REG_SAFE_PULSE:     cfg.safe_pulse_us     <= cfg_data[SAFE_W-1:0];
        REG_DEFAULT_CHARGE: cfg.default_charge_us <= cfg_data[DUR_W-1:0];
        REG_DISCHARGE:      cfg.discharge_us      <= cfg_data[DUR_W-1:0];
        REG_GOAL_CHARGE:    cfg.goal_charge_us    <= cfg_data[DUR_W-1:0];
        REG_PASS_CHARGE:    cfg.pass_charge_us    <= cfg_data[DUR_W-1:0];
        REG_CHIP_CHARGE:    cfg.chip_charge_us    <= cfg_data[DUR_W-1:0];
        REG_KICKER_MODE:    cfg.kicker_mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  skc_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  `SKC_ASSERT_NXT(a_advance_fills_out, advance, out_valid)
  `SKC_ASSERT_IMP(a_one_line_low, out_valid, out_item.discharge1_n || out_item.discharge2_n)
  `SKC_ASSERT_NXT(a_input_holds, in_valid_q && !advance, in_valid_q && $stable(in_q))

endmodule

### tb/tb_solenoid_kicker_sequencer_unit.sv
module tb_solenoid_kicker_sequencer_unit;
  import skc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 8;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  skc_in_t           in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  skc_out_t          out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  solenoid_kicker_sequencer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // kicker model state
  skc_cfg_t           cfg_now;
  logic               chg_on, kick_on, safe_on, kick_line;
  logic [DUR_W-1:0]   chg_left, kick_left;
  logic [COUNT_W-1:0] shot_count;

  skc_out_t pending_outs[$];

  int fail_cnt    = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_writes    = 0;
  int idle_cycles = 0;
  int hold_left   = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  bit quiet       = 1'b0;

  typedef struct packed {
    logic              is_cfg;
    skc_reg_e          reg_idx;
    logic [DATA_W-1:0] data;
    logic [2:0]        op;
    logic [1:0]        speed;
    logic [15:0]       reps;
    logic              typed;
    skc_out_t          want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void count_bump();
    if (shot_count != COUNT_MAX) shot_count++;
  endfunction

  function automatic void chg_finish();
    chg_on   = 1'b0;
    chg_left = '0;
    count_bump();
  endfunction

  function automatic void kick_finish();
    kick_on    = 1'b0;
    safe_on    = 1'b0;
    kick_left  = '0;
    shot_count = '0;
  endfunction

  function automatic skc_out_t kicker_next(input skc_in_t it);
    skc_out_t    r;
    skc_status_e st;
    st = ST_DONE;
    case (it.op)
      OP_TICK: begin
        if (chg_on) begin
          if (chg_left <= 1) chg_finish();
          else chg_left--;
        end
        if (kick_on) begin
          if (kick_left <= 1) kick_finish();
          else kick_left--;
        end
      end
      OP_CHARGE_START: begin
        if (shot_count >= {1'b0, cfg_now.max_charges}) begin
          st = ST_MAX_CHARGES;
        end else if (chg_on) begin
          st = ST_ALREADY_CHG;
        end else begin
          chg_on = 1'b1;
          case (it.speed)
            SPEED_GOAL: chg_left = cfg_now.goal_charge_us;
            SPEED_PASS: chg_left = cfg_now.pass_charge_us;
            SPEED_CHIP: chg_left = cfg_now.chip_charge_us;
            default:    chg_left = cfg_now.default_charge_us;
          endcase
          count_bump();
        end
      end
      OP_CHARGE_STOP: chg_finish();
      OP_KICK_START: begin
        if (kick_on) begin
          st = ST_ALREADY_KICK;
        end else begin
          kick_on   = 1'b1;
          safe_on   = 1'b0;
          kick_line = cfg_now.kicker_mode;
          kick_left = cfg_now.discharge_us;
        end
      end
      OP_KICK_STOP: kick_finish();
      OP_SAFE_KICK: begin
        if (kick_on) begin
          st = ST_ALREADY_KICK;
        end else begin
          kick_on   = 1'b1;
          safe_on   = 1'b1;
          kick_line = 1'b0;
          kick_left = DUR_W'(cfg_now.safe_pulse_us);
        end
      end
      default: ;
    endcase
    r.charge_out   = chg_on;
    r.discharge1_n = !(kick_on && kick_line);
    r.discharge2_n = !(kick_on && !kick_line);
    r.is_charging  = chg_on;
    r.is_kicking   = kick_on;
    r.charge_total = shot_count;
    r.status       = st;
    return r;
  endfunction

  function automatic skc_out_t outs(input logic chg, input logic d1n, input logic d2n,
                                    input logic kick, input int total,
                                    input skc_status_e st);
    skc_out_t r;
    r.charge_out   = chg;
    r.discharge1_n = d1n;
    r.discharge2_n = d2n;
    r.is_charging  = chg;
    r.is_kicking   = kick;
    r.charge_total = COUNT_W'(total);
    r.status       = st;
    return r;
  endfunction

  function automatic void add_cmd(input logic [2:0] op, input logic [1:0] speed,
                                  input int reps = 1);
    dir_row_t r;
    r       = '0;
    r.op    = op;
    r.speed = speed;
    r.reps  = 16'(reps);
    dir_rows.push_back(r);
  endfunction

  function automatic void add_chk(input logic [2:0] op, input logic [1:0] speed,
                                  input skc_out_t want);
    dir_row_t r;
    r       = '0;
    r.op    = op;
    r.speed = speed;
    r.reps  = 1;
    r.typed = 1'b1;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_reg(input skc_reg_e idx, input logic [DATA_W-1:0] data);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.data    = data;
    dir_rows.push_back(r);
  endfunction

  function automatic skc_cfg_t rand_cfg(input int unsigned max_dur);
    skc_cfg_t c;
    c.max_charges       = MAXC_W'($urandom_range(15));
    c.safe_pulse_us     = SAFE_W'($urandom_range(max_dur));
    c.default_charge_us = DUR_W'($urandom_range(max_dur));
    c.discharge_us      = DUR_W'($urandom_range(max_dur));
    c.goal_charge_us    = DUR_W'($urandom_range(max_dur));
    c.pass_charge_us    = DUR_W'($urandom_range(max_dur));
    c.chip_charge_us    = DUR_W'($urandom_range(max_dur));
    c.kicker_mode       = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic send_item(input skc_in_t it, input logic typed, input skc_out_t want);
    skc_out_t pred;
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = kicker_next(it);
    pending_outs.push_back(typed ? want : pred);
    n_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input skc_reg_e idx, input logic [DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAX_CHARGES:    cfg_now.max_charges       = data[MAXC_W-1:0];
      REG_SAFE_PULSE:     cfg_now.safe_pulse_us     = data[SAFE_W-1:0];
      REG_DEFAULT_CHARGE: cfg_now.default_charge_us = data[DUR_W-1:0];
      REG_DISCHARGE:      cfg_now.discharge_us      = data[DUR_W-1:0];
      REG_GOAL_CHARGE:    cfg_now.goal_charge_us    = data[DUR_W-1:0];
      REG_PASS_CHARGE:    cfg_now.pass_charge_us    = data[DUR_W-1:0];
      REG_CHIP_CHARGE:    cfg_now.chip_charge_us    = data[DUR_W-1:0];
      REG_KICKER_MODE:    cfg_now.kicker_mode       = data[0];
      default: ;
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input skc_cfg_t c);
    logic [DATA_W-1:0] junk;
    junk = DATA_W'($urandom);
    wait_idle();
    // narrow registers get random upper bits that must be dropped
    write_reg(REG_MAX_CHARGES, {junk[DATA_W-1:MAXC_W], c.max_charges});
    write_reg(REG_SAFE_PULSE, {junk[DATA_W-1:SAFE_W], c.safe_pulse_us});
    write_reg(REG_DEFAULT_CHARGE, c.default_charge_us);
    write_reg(REG_DISCHARGE, c.discharge_us);
    write_reg(REG_GOAL_CHARGE, c.goal_charge_us);
    write_reg(REG_PASS_CHARGE, c.pass_charge_us);
    write_reg(REG_CHIP_CHARGE, c.chip_charge_us);
    write_reg(REG_KICKER_MODE, {junk[DATA_W-1:1], c.kicker_mode});
  endtask

  task automatic run_phase(input int n);
    skc_in_t it;
    int      p;
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 40)      it.op = OP_TICK;
      else if (p < 55) it.op = OP_CHARGE_START;
      else if (p < 63) it.op = OP_CHARGE_STOP;
      else if (p < 75) it.op = OP_KICK_START;
      else if (p < 82) it.op = OP_KICK_STOP;
      else if (p < 92) it.op = OP_SAFE_KICK;
      else             it.op = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
      it.speed = 2'($urandom_range(3));
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin : check_outs
    skc_out_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_outs.size() == 0) begin
        $error("result with nothing expected: %h", out_item);
        fail_cnt++;
      end else begin
        want = pending_outs.pop_front();
        if (out_item.charge_out !== want.charge_out) begin
          $error("charge_out exp %0d got %0d", want.charge_out, out_item.charge_out);
          fail_cnt++;
        end
        if (out_item.discharge1_n !== want.discharge1_n) begin
          $error("discharge1_n exp %0d got %0d", want.discharge1_n, out_item.discharge1_n);
          fail_cnt++;
        end
        if (out_item.discharge2_n !== want.discharge2_n) begin
          $error("discharge2_n exp %0d got %0d", want.discharge2_n, out_item.discharge2_n);
          fail_cnt++;
        end
        if (out_item.is_charging !== want.is_charging) begin
          $error("is_charging exp %0d got %0d", want.is_charging, out_item.is_charging);
          fail_cnt++;
        end
        if (out_item.is_kicking !== want.is_kicking) begin
          $error("is_kicking exp %0d got %0d", want.is_kicking, out_item.is_kicking);
          fail_cnt++;
        end
        if (out_item.charge_total !== want.charge_total) begin
          $error("charge_total exp %0d got %0d", want.charge_total, out_item.charge_total);
          fail_cnt++;
        end
        if (out_item.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_item.status);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    skc_cfg_t c;
    skc_in_t  it;
    dir_row_t row;

    cfg_now = '{RST_MAX_CHARGES, RST_SAFE_PULSE, RST_DEFAULT_CHARGE, RST_DISCHARGE,
                RST_GOAL_CHARGE, RST_PASS_CHARGE, RST_CHIP_CHARGE, 1'b0};
    chg_on     = 1'b0;
    kick_on    = 1'b0;
    safe_on    = 1'b0;
    kick_line  = 1'b0;
    chg_left   = '0;
    kick_left  = '0;
    shot_count = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: limit of six charges, straight mode, safe pulse of 15 ticks
    add_chk(OP_TICK, SPEED_DEFAULT, outs(0, 1, 1, 0, 0, ST_DONE));
    add_chk(OP_CHARGE_START, SPEED_DEFAULT, outs(1, 1, 1, 0, 1, ST_DONE));
    add_chk(OP_CHARGE_START, SPEED_GOAL, outs(1, 1, 1, 0, 1, ST_ALREADY_CHG));
    add_chk(OP_CHARGE_STOP, SPEED_DEFAULT, outs(0, 1, 1, 0, 2, ST_DONE));
    add_chk(OP_CHARGE_STOP, SPEED_PASS, outs(0, 1, 1, 0, 3, ST_DONE));
    add_cmd(OP_CHARGE_START, SPEED_CHIP);
    add_chk(OP_KICK_START, SPEED_DEFAULT, outs(1, 1, 0, 1, 4, ST_DONE));
    add_chk(OP_KICK_START, SPEED_DEFAULT, outs(1, 1, 0, 1, 4, ST_ALREADY_KICK));
    add_chk(OP_SAFE_KICK, SPEED_DEFAULT, outs(1, 1, 0, 1, 4, ST_ALREADY_KICK));
    add_chk(OP_KICK_STOP, SPEED_DEFAULT, outs(1, 1, 1, 0, 0, ST_DONE));
    add_cmd(OP_CHARGE_STOP, SPEED_DEFAULT);
    add_cmd(OP_UNUSED_6, SPEED_CHIP);
    add_cmd(OP_UNUSED_7, SPEED_DEFAULT);
    add_chk(OP_KICK_STOP, SPEED_DEFAULT, outs(0, 1, 1, 0, 0, ST_DONE));
    add_cmd(OP_CHARGE_START, SPEED_PASS);
    add_cmd(OP_CHARGE_STOP, SPEED_DEFAULT);
    add_cmd(OP_CHARGE_START, SPEED_DEFAULT);
    add_cmd(OP_CHARGE_STOP, SPEED_DEFAULT);
    add_cmd(OP_CHARGE_STOP, SPEED_DEFAULT);
    add_cmd(OP_CHARGE_START, SPEED_CHIP);
    // count limit wins over a running charge
    add_chk(OP_CHARGE_START, SPEED_GOAL, outs(1, 1, 1, 0, 6, ST_MAX_CHARGES));
    add_chk(OP_SAFE_KICK, SPEED_DEFAULT, outs(1, 1, 0, 1, 6, ST_DONE));
    add_cmd(OP_TICK, SPEED_DEFAULT, 14);
    add_chk(OP_TICK, SPEED_DEFAULT, outs(1, 1, 1, 0, 0, ST_DONE));
    add_cmd(OP_CHARGE_STOP, SPEED_DEFAULT);
    // zero discharge time, short charge, chipper mode
    add_reg(REG_DISCHARGE, '0);
    add_reg(REG_DEFAULT_CHARGE, DATA_W'(2));
    add_reg(REG_KICKER_MODE, '1);
    add_cmd(OP_CHARGE_START, SPEED_DEFAULT);
    add_cmd(OP_TICK, SPEED_DEFAULT);
    add_chk(OP_KICK_START, SPEED_DEFAULT, outs(1, 0, 1, 1, 2, ST_DONE));
    // both timers run out on one tick, kick stop last
    add_chk(OP_TICK, SPEED_DEFAULT, outs(0, 1, 1, 0, 0, ST_DONE));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.reg_idx, row.data);
      end else begin
        it.op    = row.op;
        it.speed = row.speed;
        repeat (row.reps) send_item(it, row.typed, row.want);
      end
    end

    c = rand_cfg(6);
    c.max_charges = 4'd15;
    c.kicker_mode = 1'b0;
    apply_cfg(c);
    run_phase(100);

    c = '0;
    c.kicker_mode = 1'b1;
    apply_cfg(c);
    run_phase(80);

    c = '1;
    c.kicker_mode = 1'($urandom_range(1));
    apply_cfg(c);
    run_phase(80);

    apply_cfg(rand_cfg(10));
    hold_req = 1'b1;
    run_phase(120);

    apply_cfg(rand_cfg(4));
    quiet = 1'b1;
    run_phase(120);
    quiet = 1'b0;

    apply_cfg(rand_cfg(20));
    run_phase(100);

    wait_idle();

    $display("%0d commands sent and %0d results checked", n_items, n_results);
    $display("%0d register writes over all eight settings, including all-zero and all-one",
             n_writes);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/skc_pkg.sv
rtl/core/skc_core.sv
rtl/core/solenoid_kicker_sequencer_unit.sv
tb/tb_solenoid_kicker_sequencer_unit.sv
